FILE: hdl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Command codes, round constants, initial hash and the SHA-256 bit functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

  // Command codes carried on the input word.
  localparam logic [1:0] CMD_APPEND     = 2'd0;
  localparam logic [1:0] CMD_APPEND_FIN = 2'd1;
  localparam logic [1:0] CMD_FINISH     = 2'd2;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned BLOCK_BITS  = 8 * BLOCK_BYTES;
  localparam int unsigned COUNT_W     = 61;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [7:0][31:0] H_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Control group from the byte sequencer to the compression unit.
  typedef struct packed {
    logic start;
    logic init;
  } cmp_ctl_t;

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sha256_if.sv
// ----------------------------------------------------------------------------
// SHA-256 stream interfaces
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

`default_nettype wire

FILE: hdl/sha256_compress.sv
// ----------------------------------------------------------------------------
// SHA-256 compression unit
// One shared round datapath, stepped through all 64 rounds of a block, plus the final add.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_compress import sha256_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cmp_ctl_t              ctl_i,
  input  wire logic [BLOCK_BITS-1:0] block_i,
  output logic                       done_o,
  output logic [7:0][31:0]           hash_o
);

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_RUN  = 3'b010,
    C_ADD  = 3'b100
  } cst_e;

  cst_e             state_q, state_d;
  logic [5:0]       rnd_q, rnd_d;
  logic [7:0][31:0] h_q, h_d;
  logic [7:0][31:0] v_q, v_d;
  logic [15:0][31:0] w_q, w_d;

  logic [31:0] w_new, w_cur, t1, t2, ch, maj;

  // Rolling schedule: w_q[0] is the oldest of the last sixteen words.
  always_comb begin
    w_new = w_q[0] + ssig0(w_q[1]) + w_q[9] + ssig1(w_q[14]);
    w_cur = (rnd_q[5:4] == 2'b00) ? w_q[0] : w_new;
    ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1    = v_q[7] + bsig1(v_q[4]) + ch + ROUND_K[rnd_q] + w_cur;
    t2    = bsig0(v_q[0]) + maj;
  end

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    h_d     = h_q;
    v_d     = v_q;
    w_d     = w_q;
    done_o  = 1'b0;
    case (state_q)
      C_IDLE: begin
        if (ctl_i.init) begin
          h_d = H_INIT;
        end
        if (ctl_i.start) begin
          for (int j = 0; j < 16; j++) begin
            w_d[j] = block_i[BLOCK_BITS-1-32*j -: 32];
          end
          v_d     = h_q;
          rnd_d   = '0;
          state_d = C_RUN;
        end
      end
      C_RUN: begin
        v_d = {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
        w_d = {w_cur, w_q[15:1]};
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = C_ADD;
        end
      end
      C_ADD: begin
        for (int j = 0; j < 8; j++) begin
          h_d[j] = h_q[j] + v_q[j];
        end
        done_o  = 1'b1;
        state_d = C_IDLE;
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      rnd_q   <= '0;
      h_q     <= H_INIT;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      h_q     <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    w_q <= w_d;
  end

  assign hash_o = h_q;

endmodule

`default_nettype wire

FILE: hdl/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Byte intake, padding sequencer and digest output around one round unit.
// ----------------------------------------------------------------------------
// Message bytes arrive one word per handshake on in_i and are shifted into a
// 512-bit block register; an ordinary byte does not stall intake. When the
// sixty-fourth byte of a block lands, intake stops while the block is handed
// over and while the compression unit runs one SHA-256 round per clock
// through a single shared round datapath and then adds the working
// variables into the chaining state. A finish command (with or without a
// final byte) makes the sequencer feed the pad byte, zero fill and the
// 64-bit big-endian bit length through the same byte path, one byte per
// cycle, so finishing costs the fill up to the block end plus one
// compression, or a further block of fill and a second compression when
// the length does not fit behind the pad byte. The eight digest words then
// leave on out_o, most significant first, one per accepted word; in_i stays
// not ready until the last one is taken, after which the hash state returns
// to its initial value and a new message may start at once. Command code
// three is accepted and ignored. The byte count wraps modulo 2^61.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_message_hasher import sha256_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  sha256_in_if.sink    in_i,
  sha256_out_if.source out_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,  // taking message bytes
    S_PAD  = 5'b00010,  // feeding pad, fill and length bytes
    S_LOAD = 5'b00100,  // handing a full block to the round unit
    S_COMP = 5'b01000,  // waiting for the round unit
    S_OUT  = 5'b10000   // sending digest words
  } st_e;

  st_e                   state_q, state_d;
  logic [5:0]            pos_q, pos_d;
  logic [COUNT_W-1:0]    cnt_q, cnt_d;
  logic                  pad80_q, pad80_d;   // pad byte still to be sent
  logic                  len_ok_q, len_ok_d; // this block carries the length
  logic                  fin_q, fin_d;       // a finish is in progress
  logic                  last_q, last_d;     // block in flight is the final one
  logic [2:0]            widx_q, widx_d;
  logic [BLOCK_BITS-1:0] blk_q;

  logic             in_acc, out_acc;
  logic             shift_en, wrap;
  logic [7:0]       shift_byte, pad_byte, len_byte;
  logic [63:0]      len_bits;
  cmp_ctl_t         cmp_ctl;
  logic             cmp_done;
  logic [7:0][31:0] hash;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  // The length bytes go out big-endian at block positions 56 to 63.
  assign len_bits = {cnt_q, 3'b000};
  assign len_byte = len_bits[{~pos_q[2:0], 3'b000} +: 8];
  assign pad_byte = pad80_q ? PAD_BYTE
                  : ((len_ok_q && (pos_q[5:3] == 3'b111)) ? len_byte : 8'h00);

  always_comb begin
    shift_en   = 1'b0;
    shift_byte = pad_byte;
    cnt_d      = cnt_q;
    if (state_q == S_PAD) begin
      shift_en = 1'b1;
    end else if (in_acc && (in_i.cmd == CMD_APPEND || in_i.cmd == CMD_APPEND_FIN)) begin
      shift_en   = 1'b1;
      shift_byte = in_i.data_byte;
      cnt_d      = cnt_q + COUNT_W'(1);
    end
    wrap  = shift_en && (pos_q == 6'd63);
    pos_d = shift_en ? pos_q + 6'd1 : pos_q;
  end

  always_comb begin
    state_d      = state_q;
    pad80_d      = pad80_q;
    len_ok_d     = len_ok_q;
    fin_d        = fin_q;
    last_d       = last_q;
    widx_d       = widx_q;
    cmp_ctl      = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_i.cmd)
            CMD_APPEND: begin
              if (wrap) begin
                fin_d   = 1'b0;
                last_d  = 1'b0;
                state_d = S_LOAD;
              end
            end
            CMD_APPEND_FIN: begin
              fin_d    = 1'b1;
              pad80_d  = 1'b1;
              len_ok_d = 1'b0;
              last_d   = 1'b0;
              state_d  = wrap ? S_LOAD : S_PAD;
            end
            CMD_FINISH: begin
              fin_d    = 1'b1;
              pad80_d  = 1'b1;
              len_ok_d = 1'b0;
              state_d  = S_PAD;
            end
            default: begin
            end
          endcase
        end
      end
      S_PAD: begin
        if (pad80_q) begin
          pad80_d = 1'b0;
          // The length fits only if the pad byte lands before position 56.
          len_ok_d = (pos_q[5:3] != 3'b111);
        end
        if (wrap) begin
          last_d   = len_ok_q;
          len_ok_d = 1'b1;
          state_d  = S_LOAD;
        end
      end
      S_LOAD: begin
        cmp_ctl.start = 1'b1;
        state_d       = S_COMP;
      end
      S_COMP: begin
        if (cmp_done) begin
          if (!fin_q) begin
            state_d = S_IDLE;
          end else if (last_q) begin
            widx_d  = '0;
            state_d = S_OUT;
          end else begin
            state_d = S_PAD;
          end
        end
      end
      S_OUT: begin
        if (out_acc) begin
          widx_d = widx_q + 3'd1;
          if (widx_q == 3'd7) begin
            cmp_ctl.init = 1'b1;
            fin_d        = 1'b0;
            state_d      = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pos_q    <= '0;
      cnt_q    <= '0;
      pad80_q  <= 1'b0;
      len_ok_q <= 1'b0;
      fin_q    <= 1'b0;
      last_q   <= 1'b0;
      widx_q   <= '0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      // The count restarts once the last digest word has gone.
      cnt_q    <= cmp_ctl.init ? '0 : cnt_d;
      pad80_q  <= pad80_d;
      len_ok_q <= len_ok_d;
      fin_q    <= fin_d;
      last_q   <= last_d;
      widx_q   <= widx_d;
    end
  end

  // Block register: bytes enter at the bottom, so byte 0 ends up on top.
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      blk_q <= {blk_q[BLOCK_BITS-9:0], shift_byte};
    end
  end

  sha256_compress u_compress (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (cmp_ctl),
    .block_i (blk_q),
    .done_o  (cmp_done),
    .hash_o  (hash)
  );

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = (state_q == S_OUT);
  assign out_o.digest_word = hash[widx_q];
  assign out_o.word_index  = widx_q;
  assign out_o.last_word   = (widx_q == 3'd7);

endmodule

`default_nettype wire

FILE: hdl/sha256_chk.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher port checker
// Watches the top-level channels and checks digest sequencing over time.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_word_i,
  input wire logic [2:0]  out_index_i,
  input wire logic        out_last_i
);

  // A stalled digest word must stay put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i)
      && $stable(out_index_i))
    else $error("digest word changed while stalled");

  // The block never takes bytes while it is sending a digest.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready while digest is pending");

  // Words of one digest follow in order without a gap in the index.
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=>
      out_valid_i && (out_index_i == $past(out_index_i) + 3'd1))
    else $error("digest word index out of sequence");

  // The last flag marks exactly the eighth word.
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_last_i == (out_index_i == 3'd7)))
    else $error("last flag does not match word index");

  // After the last word the block is ready for a new message.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_last_i |=> !out_valid_i && in_ready_i)
    else $error("block did not return to intake after digest");

endmodule

bind sha256_message_hasher sha256_chk u_sha256_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_word_i  (out_o.digest_word),
  .out_index_i (out_o.word_index),
  .out_last_i  (out_o.last_word)
);

`default_nettype wire

FILE: dv/sha256_digest_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches both channels. It hashes every accepted byte with its own SHA-256
// implementation and compares each digest word that leaves the hasher
// against the oldest word still due.
// ----------------------------------------------------------------------------
module sha256_digest_checker import sha256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sha256_in_if        in_mon,
  sha256_out_if       out_mon,
  output int unsigned mismatch_cnt_o,
  output int unsigned words_due_o
);

  localparam logic [7:0] PAD = 8'h80;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  digest_word_t digest_due [$];

  logic [31:0] chain   [8];
  logic [7:0]  blk     [64];
  logic [5:0]  fill;
  logic [60:0] msg_len;
  int unsigned mismatches;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic start_message();
    chain   = IV;
    fill    = '0;
    msg_len = '0;
  endtask

  // One full 64-round compression of blk into the chaining value.
  task automatic run_rounds();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] t1, t2, wr, s0, s1, w15, w2;
    for (int j = 0; j < 16; j++)
      w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        w15 = w[(r + 1) % 16];
        w2  = w[(r + 14) % 16];
        s0  = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
        s1  = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
        wr  = w[r % 16] + s0 + w[(r + 9) % 16] + s1;
        w[r % 16] = wr;
      end
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + RK[r] + wr;
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endtask

  task automatic take_byte(input logic [7:0] data);
    blk[fill] = data;
    fill      = fill + 6'd1;
    msg_len   = msg_len + 61'd1;
    if (fill == 6'd0) run_rounds();
  endtask

  // Pads the message, compresses the tail and queues the eight digest words.
  task automatic close_message();
    logic [63:0]  bit_len;
    int unsigned  p;
    digest_word_t dw;
    bit_len = {msg_len, 3'b000};
    p = fill;
    blk[p] = PAD;
    p++;
    if (p > 56) begin
      while (p < 64) begin
        blk[p] = 8'h00;
        p++;
      end
      run_rounds();
      p = 0;
    end
    while (p < 56) begin
      blk[p] = 8'h00;
      p++;
    end
    for (int i = 0; i < 8; i++) blk[63 - i] = bit_len[8*i +: 8];
    run_rounds();
    for (int i = 0; i < 8; i++) begin
      dw.word  = chain[i];
      dw.index = 3'(i);
      dw.last  = (i == 7);
      digest_due.push_back(dw);
    end
    start_message();
  endtask

  task automatic check_word(input logic [31:0] word, input logic [2:0] index,
                            input logic last);
    digest_word_t want;
    if (digest_due.size() == 0) begin
      if (mismatches < 10)
        $display("MISMATCH: unexpected digest word %h index %0d last %0b",
                 word, index, last);
      mismatches++;
      return;
    end
    want = digest_due.pop_front();
    if (want.word !== word || want.index !== index || want.last !== last) begin
      if (mismatches < 10)
        $display("MISMATCH: expected %h index %0d last %0b, got %h index %0d last %0b",
                 want.word, want.index, want.last, word, index, last);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_message();
      digest_due.delete();
      mismatches      = 0;
      mismatch_cnt_o <= 0;
      words_due_o    <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready)
        check_word(out_mon.digest_word, out_mon.word_index, out_mon.last_word);
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.cmd == CMD_APPEND || in_mon.cmd == CMD_APPEND_FIN)
          take_byte(in_mon.data_byte);
        if (in_mon.cmd == CMD_APPEND_FIN || in_mon.cmd == CMD_FINISH)
          close_message();
      end
      mismatch_cnt_o <= mismatches;
      words_due_o    <= digest_due.size();
    end
  end

endmodule

FILE: dv/sha256_message_hasher_tb.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Drives messages of many lengths into the hasher, the padding boundaries
// among them, and lets a checker compare every digest word that comes back.
// ----------------------------------------------------------------------------
module sha256_message_hasher_tb import sha256_pkg::*;;

  // Command code three has no meaning; the hasher must accept and drop it.
  localparam logic [1:0]  CMD_SPARE    = 2'd3;
  // Number of message words in the random part of the run.
  localparam int unsigned RANDOM_WORDS = 370;
  // Several messages must finish so that digests are plentiful.
  localparam int unsigned MIN_MESSAGES = 8;
  // A finish can take two padded blocks plus two compressions; this covers it.
  localparam int unsigned DRAIN_CYCLES = 300;
  // Even if every word were a finish under the slowest receiver, a run would
  // stay well inside this limit.
  localparam int unsigned LIMIT_TIME   = 20_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned mismatch_cnt;
  int unsigned words_due;
  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned words_sent;
  int unsigned messages_done;

  sha256_in_if  byte_if ();
  sha256_out_if digest_if ();

  sha256_message_hasher dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (digest_if)
  );

  sha256_digest_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (byte_if),
    .out_mon        (digest_if),
    .mismatch_cnt_o (mismatch_cnt),
    .words_due_o    (words_due)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The digest receiver stalls at random; recv_idle is the stall percentage.
  always @(posedge clk_i) begin
    digest_if.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Offers one word and returns at the edge where it is taken. Valid stays
  // high on return, so a following word goes out back to back; whoever spends
  // time afterwards without sending must lower valid first.
  task automatic push_word(input logic [1:0] cmd, input logic [7:0] data);
    while ($urandom_range(0, 99) < send_idle) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.cmd       <= cmd;
    byte_if.data_byte <= data;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    if (cmd != CMD_SPARE) words_sent++;
  endtask

  // Holds the sender back until every digest word still due has come out.
  // words_due is registered in the checker, so at each edge it shows the
  // count as of the previous edge; the first read already covers the finish.
  task automatic settle();
    byte_if.valid <= 1'b0;
    @(posedge clk_i);
    while (words_due != 0) @(posedge clk_i);
  endtask

  // Sends one whole message of len bytes. The last byte may ride on the
  // finish command or be followed by a bare finish, chosen at random. Spare
  // commands are sprinkled in as noise; they must leave the hash untouched.
  task automatic send_message(input int unsigned len);
    logic fin_with_byte;
    fin_with_byte = (len != 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) push_word(CMD_SPARE, 8'($urandom));
      if (fin_with_byte && i == len - 1)
        push_word(CMD_APPEND_FIN, 8'($urandom));
      else
        push_word(CMD_APPEND, 8'($urandom));
    end
    if (!fin_with_byte) push_word(CMD_FINISH, 8'($urandom));
    messages_done++;
  endtask

  // Most messages are short so that many digests come back. A good share sits
  // right around the point where the length field no longer fits behind the
  // pad byte (55 and 56 bytes) and around whole blocks, and some run past
  // one block so that multi-block chaining is covered.
  function automatic int unsigned pick_length();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom_range(0, 8);
    if (sel < 6) return $urandom_range(54, 65);
    if (sel < 7) return $urandom_range(118, 129);
    return $urandom_range(0, 130);
  endfunction

  initial begin
    rst_ni            <= 1'b0;
    byte_if.valid     <= 1'b0;
    byte_if.cmd       <= CMD_APPEND;
    byte_if.data_byte <= 8'h00;
    send_idle     = 18;
    recv_idle     = 83;
    words_sent    = 0;
    messages_done = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The empty message comes first, straight out of reset,
    // then the classic three-byte message, each waited out completely.
    push_word(CMD_FINISH, 8'ha5);
    settle();
    push_word(CMD_APPEND, 8'h61);
    push_word(CMD_APPEND, 8'h62);
    push_word(CMD_APPEND_FIN, 8'h63);
    settle();
    // Single-byte messages at both extremes of the byte, finished both ways.
    push_word(CMD_APPEND_FIN, 8'hff);
    push_word(CMD_APPEND, 8'h00);
    push_word(CMD_FINISH, 8'hff);
    settle();
    // A spare command in the middle of a message must change nothing, and a
    // data byte equal to the pad value must not confuse the padding.
    push_word(CMD_SPARE, 8'hff);
    push_word(CMD_APPEND, 8'h00);
    push_word(CMD_SPARE, 8'h55);
    push_word(CMD_APPEND_FIN, 8'h80);
    // A new message directly behind a finish, with no wait in between.
    push_word(CMD_APPEND, 8'h7f);
    push_word(CMD_FINISH, 8'h00);
    settle();

    // Random part in three phases: sender mostly busy with a slow receiver,
    // then a slow sender with a fast receiver, then both at full speed.
    words_sent = 0;
    while (words_sent < RANDOM_WORDS || messages_done < MIN_MESSAGES) begin
      if (words_sent < RANDOM_WORDS / 3) begin
        send_idle = 18;
        recv_idle = 83;
      end else if (words_sent < 2 * RANDOM_WORDS / 3) begin
        send_idle = 83;
        recv_idle = 18;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      send_message(pick_length());
      // Now and then let the hasher run dry before the next message.
      if ($urandom_range(0, 3) == 0) settle();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #(LIMIT_TIME);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
hdl/sha256_pkg.sv
hdl/sha256_if.sv
hdl/sha256_compress.sv
hdl/sha256_message_hasher.sv
hdl/sha256_chk.sv
dv/sha256_digest_checker.sv
dv/sha256_message_hasher_tb.sv
